// ===== design/hsv2rgb_pkg.sv =====
// hsv2rgb_pkg: widths, constants and the hue sector type of the HSV to RGB converter.
// No dependencies; compiled first.
`default_nettype none

package hsv2rgb_pkg;

	localparam int HUE_W    = 9;
	localparam int CHAN_W   = 8;
	localparam int FRAC_W   = 6;
	localparam int SCALE_W  = 14;
	localparam int PACKED_W = 3 * CHAN_W;

	localparam int NUM_SECTORS = 6;

	localparam logic [HUE_W-1:0]   FULL_TURN  = 9'd360;
	localparam logic [FRAC_W-1:0]  SECTOR_DEG = 6'd60;
	localparam logic [CHAN_W-1:0]  CHAN_MAX   = 8'd255;
	localparam logic [SCALE_W-1:0] SCALE_QT   = 14'd15300;   // 255 * 60

	// floor(x / 15300) == floor((x >> 2) * RECIP_QT >> RECIP_SHIFT) for x >> 2 below 2^20
	localparam int                 RECIP_W     = 20;
	localparam logic [RECIP_W-1:0] RECIP_QT    = 20'd561434;  // ceil(2^31 / 3825)
	localparam int                 RECIP_SHIFT = 31;

	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

endpackage

`default_nettype wire

// ===== design/hsv2rgb_if.sv =====
// hsv2rgb_hsv_if / hsv2rgb_rgb_if: valid/ready channels for HSV pixels in and RGB pixels out.
// Depends on hsv2rgb_pkg.
`default_nettype none

interface hsv2rgb_hsv_if;
	logic                            valid;
	logic                            ready;
	logic [hsv2rgb_pkg::HUE_W-1:0]   hue;
	logic [hsv2rgb_pkg::CHAN_W-1:0]  saturation;
	logic [hsv2rgb_pkg::CHAN_W-1:0]  brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_rgb_if;
	logic                              valid;
	logic                              ready;
	logic [hsv2rgb_pkg::CHAN_W-1:0]    red;
	logic [hsv2rgb_pkg::CHAN_W-1:0]    green;
	logic [hsv2rgb_pkg::CHAN_W-1:0]    blue;
	logic [hsv2rgb_pkg::PACKED_W-1:0]  packed_color;

	modport source (output valid, red, green, blue, packed_color, input ready);
	modport sink   (input valid, red, green, blue, packed_color, output ready);
endinterface

`default_nettype wire

// ===== design/hsv_to_rgb_converter.sv =====
// hsv_to_rgb_converter: five-stage pipelined HSV to 8-bit RGB pixel converter.
// Depends on hsv2rgb_pkg and the channel interfaces in hsv2rgb_if.sv.
//
// Usage
//   hsv : sink channel, one HSV pixel (hue 0..359, saturation, brightness) per transfer.
//         A hue of 360..511 is folded back by one full turn.
//   rgb : source channel, red/green/blue plus the packed 24-bit word per transfer.
//   A transfer happens on a rising clk edge with valid and ready both high.
// Throughput: one pixel per clock, sustained, while the receiver keeps ready high.
// Pipeline: an input transfer passes through s1 to s5 before showing on rgb.valid.
//   s1  hue fold, sector and remainder (compare chain)
//   s2  s*f and s*(60-f), 15300 minus each, 255 - s
//   s3  v times each numerator
//   s4  divide by 255 (add/shift) and by 15300 (reciprocal multiply, 20x20)
//   s5  sector permutation into the output register
// Stall: each stage holds while the stage ahead is full and stalled, so bubbles
//   collapse and up to five pixels sit in flight; hsv.ready drops only once
//   every stage is full and rgb.ready is low. Nothing is dropped or repeated.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
// The block keeps no state between pixels.
`default_nettype none

module hsv_to_rgb_converter (
	input  wire logic     clk,
	input  wire logic     arst_n,
	hsv2rgb_hsv_if.sink   hsv,
	hsv2rgb_rgb_if.source rgb
);
	import hsv2rgb_pkg::*;

	localparam int PV_W = 2 * CHAN_W;          // v * (255 - s)
	localparam int QV_W = CHAN_W + SCALE_W;    // v * (15300 - s*f)
	localparam int QZ_W = QV_W - 2;            // after the free divide by 4
	localparam int QM_W = QZ_W + RECIP_W;

	// stage enables: a stage moves when empty or when the stage ahead moves
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	assign en_s5 = !vld_s5 || rgb.ready;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;

	assign hsv.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= hsv.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
		end
	end

	// ---------------- s1: hue fold, sector and remainder
	logic [HUE_W-1:0]  hue_fold;
	logic [2:0]        sec_idx;
	logic [HUE_W-1:0]  sec_base;
	logic [FRAC_W-1:0] frac_c;

	always_comb begin
		hue_fold = (hsv.hue >= FULL_TURN) ? hsv.hue - FULL_TURN : hsv.hue;
		sec_idx  = '0;
		for (int k = 1; k < NUM_SECTORS; k++) begin
			if (hue_fold >= HUE_W'(k) * HUE_W'(SECTOR_DEG)) sec_idx = 3'(k);
		end
		sec_base = HUE_W'(sec_idx) * HUE_W'(SECTOR_DEG);
		frac_c   = FRAC_W'(hue_fold - sec_base);
	end

	sector_t           sector_s1;
	logic [FRAC_W-1:0] frac_s1;
	logic [CHAN_W-1:0] sat_s1, val_s1;

	always_ff @(posedge clk) begin
		if (en_s1 && hsv.valid) begin
			sector_s1 <= sector_t'(sec_idx);
			frac_s1   <= frac_c;
			sat_s1    <= hsv.saturation;
			val_s1    <= hsv.brightness;
		end
	end

	// ---------------- s2: numerators of p, q and t
	logic [SCALE_W-1:0] sf_c, sg_c;

	assign sf_c = SCALE_W'(sat_s1) * SCALE_W'(frac_s1);
	assign sg_c = SCALE_W'(sat_s1) * SCALE_W'(SECTOR_DEG - frac_s1);

	sector_t            sector_s2;
	logic [CHAN_W-1:0]  val_s2, np_s2;
	logic [SCALE_W-1:0] nq_s2, nt_s2;

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			sector_s2 <= sector_s1;
			val_s2    <= val_s1;
			np_s2     <= CHAN_MAX - sat_s1;
			nq_s2     <= SCALE_QT - sf_c;
			nt_s2     <= SCALE_QT - sg_c;
		end
	end

	// ---------------- s3: scale by brightness
	sector_t           sector_s3;
	logic [CHAN_W-1:0] val_s3;
	logic [PV_W-1:0]   pv_s3;
	logic [QV_W-1:0]   qv_s3, tv_s3;

	always_ff @(posedge clk) begin
		if (en_s3 && vld_s2) begin
			sector_s3 <= sector_s2;
			val_s3    <= val_s2;
			pv_s3     <= PV_W'(val_s2) * PV_W'(np_s2);
			qv_s3     <= QV_W'(val_s2) * QV_W'(nq_s2);
			tv_s3     <= QV_W'(val_s2) * QV_W'(nt_s2);
		end
	end

	// ---------------- s4: constant divisions
	// x / 255 for x <= 65025: (x + (x >> 8) + 1) >> 8
	logic [PV_W:0]   p_sum;
	logic [QM_W-1:0] qm_c, tm_c;

	assign p_sum = (PV_W+1)'(pv_s3) + (PV_W+1)'(pv_s3 >> CHAN_W) + (PV_W+1)'(1);
	assign qm_c  = QM_W'(qv_s3[QV_W-1:2]) * QM_W'(RECIP_QT);
	assign tm_c  = QM_W'(tv_s3[QV_W-1:2]) * QM_W'(RECIP_QT);

	sector_t           sector_s4;
	logic [CHAN_W-1:0] val_s4, p_s4, q_s4, t_s4;

	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3) begin
			sector_s4 <= sector_s3;
			val_s4    <= val_s3;
			p_s4      <= p_sum[2*CHAN_W-1:CHAN_W];
			q_s4      <= qm_c[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
			t_s4      <= tm_c[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
		end
	end

	// ---------------- s5: sector permutation, output register
	logic [CHAN_W-1:0] red_c, green_c, blue_c;

	always_comb begin
		unique case (sector_s4)
			SEC_RED:    begin red_c = val_s4; green_c = t_s4;   blue_c = p_s4;   end
			SEC_YELLOW: begin red_c = q_s4;   green_c = val_s4; blue_c = p_s4;   end
			SEC_GREEN:  begin red_c = p_s4;   green_c = val_s4; blue_c = t_s4;   end
			SEC_CYAN:   begin red_c = p_s4;   green_c = q_s4;   blue_c = val_s4; end
			SEC_BLUE:   begin red_c = t_s4;   green_c = p_s4;   blue_c = val_s4; end
			default:    begin red_c = val_s4; green_c = p_s4;   blue_c = q_s4;   end
		endcase
	end

	logic [CHAN_W-1:0] red_s5, green_s5, blue_s5;

	always_ff @(posedge clk) begin
		if (en_s5 && vld_s4) begin
			red_s5   <= red_c;
			green_s5 <= green_c;
			blue_s5  <= blue_c;
		end
	end

	assign rgb.valid        = vld_s5;
	assign rgb.red          = red_s5;
	assign rgb.green        = green_s5;
	assign rgb.blue         = blue_s5;
	assign rgb.packed_color = {red_s5, green_s5, blue_s5};

endmodule

`default_nettype wire

// ===== design/hsv2rgb_checker.sv =====
// hsv2rgb_checker: port-level assertions for hsv_to_rgb_converter, bound into each instance of it.
// Depends on hsv2rgb_pkg and hsv_to_rgb_converter.
`default_nettype none

module hsv2rgb_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             hsv_valid,
	input wire logic                             hsv_ready,
	input wire logic                             rgb_valid,
	input wire logic                             rgb_ready,
	input wire logic [hsv2rgb_pkg::CHAN_W-1:0]   red,
	input wire logic [hsv2rgb_pkg::CHAN_W-1:0]   green,
	input wire logic [hsv2rgb_pkg::CHAN_W-1:0]   blue,
	input wire logic [hsv2rgb_pkg::PACKED_W-1:0] packed_color
);
	import hsv2rgb_pkg::*;

	// packed word agrees with the separate channels whenever a result is offered
	a_packed_matches: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid |-> packed_color == {red, green, blue})
		else $error("packed_color differs from red/green/blue");

	// a pixel taken in is followed by a result offered on rgb, checked where an unstalled pixel reaches the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && hsv_ready) |-> ##5 rgb_valid)
		else $error("no result five cycles after input transfer");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rgb_valid && !rgb_ready) |=> rgb_valid)
		else $error("result withdrawn while stalled");

	// and keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(rgb_valid && !rgb_ready) |=> $stable(packed_color))
		else $error("result changed while stalled");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.hsv_valid    (hsv.valid),
	.hsv_ready    (hsv.ready),
	.rgb_valid    (rgb.valid),
	.rgb_ready    (rgb.ready),
	.red          (rgb.red),
	.green        (rgb.green),
	.blue         (rgb.blue),
	.packed_color (rgb.packed_color)
);

`default_nettype wire
